// ===== design/mbp_pkg.sv =====
`timescale 1ns / 1ps
package mbp_pkg;

	localparam int BYTE_BITS  = 8;
	localparam int CODE_MAX   = 32;
	localparam int TOTAL_W    = 48;
	localparam int MAX_BYTES  = 4;

	localparam logic FUNC_PUT   = 1'b0;
	localparam logic FUNC_ALIGN = 1'b1;

	typedef struct packed {
		logic        func;
		logic [31:0] value;
		logic [5:0]  bit_count;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		logic               last_of_run;
		logic [TOTAL_W-1:0] total_bits;
	} out_item_t;

	// bytes[0] is the first byte of the stream
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                nbytes;
		logic [TOTAL_W-1:0]        total;
	} job_t;

	typedef struct packed {
		logic [3:0] free_bits;
	} front_stat_t;

endpackage

// ===== design/msb_first_bit_packer.sv =====
// MSB-first bit packer.
// Request channel: push/full. A put request appends the low bit_count bits of
// value (counts above 32 act as 32); an align request pads with zeros to the
// next byte boundary. Result channel: empty/pop. Each completed byte comes out
// with last_of_run set on the final byte of its request and the saturating
// running bit total.
// One request is taken every cycle while the job queue (DEPTH entries) has
// room; a request that completes no byte uses no queue slot. The back end
// emits one byte per cycle while its output register is free or being popped,
// so a request completing k bytes occupies it until all k are out. The first
// byte of a request passes the queue write, the job load and the output register.
// Reset clears the partial byte, the bit total, the queue and the output valid flag.
// When pop stays low the output holds, the back end stops, the queue fills
// and full rises until results drain.
`timescale 1ns / 1ps
module msb_first_bit_packer
	import mbp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic        accept;
	job_t        f_job;
	logic        f_push;
	front_stat_t f_stat;
	job_t        q_data;
	logic        q_empty;
	logic        q_full;
	logic        q_pop;

	assign full   = q_full;
	assign accept = push && !q_full;

	mbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.job      (f_job),
		.job_push (f_push),
		.stat     (f_stat)
	);

	mbp_jobq #(
		.DEPTH (DEPTH)
	) u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data (f_job),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	mbp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

`ifndef SYNTHESIS
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		f_stat.free_bits >= 4'd1 && f_stat.free_bits <= 4'(BYTE_BITS))
		else $error("free bit count out of range");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last_of_run) |=>
		(!empty && $stable(result.total_bits)))
		else $error("run broken before its last byte");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && result.last_of_run) |=>
		(empty || result.total_bits >= $past(result.total_bits)))
		else $error("bit total went backwards");
`endif

endmodule

// ===== design/mbp_front.sv =====
`timescale 1ns / 1ps
module mbp_front
	import mbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  in_item_t    item,
	output job_t        job,
	output logic        job_push,
	output front_stat_t stat
);

	logic [7:0]         partial_q;
	logic [3:0]         free_q;
	logic [TOTAL_W-1:0] total_q;

	logic [2:0]         used;
	logic [5:0]         count_eff;
	logic [31:0]        value_eff;
	logic [31:0]        v_al;
	logic [39:0]        win;
	logic [4:0][7:0]    wb;
	logic [5:0]         n_bits;
	logic [2:0]         nb;
	logic [2:0]         rem;
	logic [7:0]         rem_byte;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total_nx;

	always_comb begin
		used = 3'(4'(BYTE_BITS) - free_q);
		if (item.func == FUNC_ALIGN) begin
			value_eff = '0;
			count_eff = (free_q == 4'(BYTE_BITS)) ? 6'd0 : {2'b00, free_q};
		end else begin
			value_eff = item.value;
			count_eff = (item.bit_count > 6'(CODE_MAX)) ? 6'(CODE_MAX) : item.bit_count;
		end
		v_al     = value_eff << (6'(CODE_MAX) - count_eff);
		win      = {partial_q, v_al} << (4'(BYTE_BITS) - {1'b0, used});
		wb       = win;
		n_bits   = {3'b000, used} + count_eff;
		nb       = n_bits[5:3];
		rem      = n_bits[2:0];
		rem_byte = wb[3'd4 - nb];
		sum      = {1'b0, total_q} + (TOTAL_W+1)'(count_eff);
		total_nx = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
	end

	always_comb begin
		for (int k = 0; k < MAX_BYTES; k++) begin
			job.bytes[k] = wb[4-k];
		end
		job.nbytes = nb;
		job.total  = total_nx;
		job_push   = accept && (nb != 3'd0);
		stat.free_bits = free_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			free_q    <= 4'(BYTE_BITS);
			total_q   <= '0;
		end else if (accept) begin
			partial_q <= rem_byte >> (4'(BYTE_BITS) - {1'b0, rem});
			free_q    <= 4'(BYTE_BITS) - {1'b0, rem};
			total_q   <= total_nx;
		end
	end

endmodule

// ===== design/mbp_jobq.sv =====
`timescale 1ns / 1ps
module mbp_jobq
	import mbp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	input  logic rd_en,
	output job_t rd_data,
	output logic q_full,
	output logic q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign q_full  = (cnt_q == CW'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/mbp_back.sv =====
`timescale 1ns / 1ps
module mbp_back
	import mbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      q_data,
	input  logic      q_empty,
	output logic      q_pop,
	input  logic      pop,
	output logic      empty,
	output out_item_t result
);

	job_t       job_q;
	logic       job_valid_q;
	logic [1:0] idx_q;
	out_item_t  out_q;
	logic       out_valid_q;

	logic slot_free;
	logic emit;
	logic finish;

	assign slot_free = !out_valid_q || pop;
	assign emit      = job_valid_q && slot_free;
	assign finish    = ({1'b0, idx_q} + 3'd1) == job_q.nbytes;
	assign q_pop     = !q_empty && (!job_valid_q || (emit && finish));
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
		end
		if (emit) begin
			out_q.out_byte    <= job_q.bytes[idx_q];
			out_q.last_of_run <= finish;
			out_q.total_bits  <= job_q.total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (emit) begin
				job_valid_q <= !finish;
				idx_q       <= idx_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
